// ===== src/pisc_pkg.sv =====
// ----------------------------------------------------------------------------
// pisc_pkg
// Shared types, constants and bit-mapping functions for the PBCH payload
// interleave / scramble / CRC24C block.
// ----------------------------------------------------------------------------
package pisc_pkg;

  localparam int WordBits  = 32;
  localparam int MsgBits   = 24;
  localparam int CrcBits   = 24;
  localparam int GoldBits  = 31;
  localparam int GoldSkip  = 1600;
  localparam int CntBits   = 11;   // holds skip + worst advance (1687)
  localparam int IdxBits   = 5;    // one position of the 32-bit word
  localparam int OtherStart = 14;

  localparam logic [CrcBits-1:0] CrcPoly = 24'hB2B117;

  // configuration register indexes
  localparam logic CfgCellId = 1'b0;
  localparam logic CfgLmax64 = 1'b1;

  // interleaver: slot -> word position
  localparam logic [4:0] IlvTab [WordBits] = '{
    5'd16, 5'd23, 5'd18, 5'd17, 5'd8,  5'd30, 5'd10, 5'd6,
    5'd24, 5'd7,  5'd0,  5'd5,  5'd3,  5'd2,  5'd1,  5'd4,
    5'd9,  5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd19, 5'd20,
    5'd21, 5'd22, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd31
  };

  typedef struct packed {
    logic [MsgBits-1:0] payload_bits;
    logic [9:0]  frame_number;
    logic        half_frame;
    logic [5:0]  block_index;
    logic [4:0]  subcarrier_offset;
  } in_item_t;

  typedef struct packed {
    logic [WordBits-1:0] scrambled_word;
    logic [CrcBits-1:0]  crc_value;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch item, seed sequence, load skip count
    logic gold_step;  // advance sequence, count down skip
    logic seq_step;   // advance sequence, capture one output bit
    logic scr_load;   // form scrambled word, clear CRC
    logic crc_step;   // one CRC bit
    logic out_load;   // move result to output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_last;
    logic idx_last;
    logic out_free;
  } dp_stat_t;

  // interleaved payload word before scrambling
  function automatic logic [WordBits-1:0] build_word(in_item_t it, logic l64);
    logic [WordBits-1:0] slot;
    logic [WordBits-1:0] w;
    slot = '0;
    w    = '0;
    for (int j = 0; j < 6; j++) slot[j] = it.payload_bits[j+1];
    slot[OtherStart] = it.payload_bits[0];
    for (int j = OtherStart + 1; j < WordBits; j++) slot[j] = it.payload_bits[j-8];
    slot[6]  = it.frame_number[3];
    slot[7]  = it.frame_number[2];
    slot[8]  = it.frame_number[1];
    slot[9]  = it.frame_number[0];
    slot[10] = it.half_frame;
    if (l64) begin
      slot[11] = it.block_index[5];
      slot[12] = it.block_index[4];
      slot[13] = it.block_index[3];
    end else begin
      slot[11] = it.subcarrier_offset[4];
      slot[12] = 1'b0;
      slot[13] = 1'b0;
    end
    for (int j = 0; j < WordBits; j++) w[IlvTab[j]] = slot[j];
    return w;
  endfunction

  // XOR with sequence bits, consuming the sequence only at unexcluded positions
  function automatic logic [WordBits-1:0] scramble(logic [WordBits-1:0] a,
                                                   logic [WordBits-1:0] seq,
                                                   logic l64);
    logic [WordBits-1:0] r;
    logic                skip;
    int                  k;
    r = a;
    k = 0;
    for (int i = 0; i < WordBits; i++) begin
      skip = (5'(i) == IlvTab[10]) || (5'(i) == IlvTab[7]) || (5'(i) == IlvTab[8]) ||
             (l64 && ((5'(i) == IlvTab[11]) || (5'(i) == IlvTab[12]) ||
                      (5'(i) == IlvTab[13])));
      if (!skip) begin
        r[i] = a[i] ^ seq[k[IdxBits-1:0]];
        k = k + 1;
      end
    end
    return r;
  endfunction

endpackage

// ===== src/pisc_dp.sv =====
// ----------------------------------------------------------------------------
// pisc_dp
// Datapath: item registers, Gold LFSR pair, skip counter, bit index,
// sequence capture, CRC24C shift register and output register.
// ----------------------------------------------------------------------------
module pisc_dp (
  input  logic                clk,
  input  logic                rst,
  input  pisc_pkg::dp_cmd_t   cmd,
  output pisc_pkg::dp_stat_t  stat,
  input  pisc_pkg::in_item_t  in_data,
  input  logic [9:0]          cell_id,
  input  logic                lmax_is_64,
  output logic                out_valid,
  input  logic                out_stall,
  output pisc_pkg::out_item_t out_data
);

  logic [pisc_pkg::WordBits-1:0] word_a;
  logic                          l64;
  logic [pisc_pkg::GoldBits-1:0] x1;
  logic [pisc_pkg::GoldBits-1:0] x2;
  logic [pisc_pkg::CntBits-1:0]  cnt;
  logic [pisc_pkg::IdxBits-1:0]  idx;
  logic [pisc_pkg::WordBits-1:0] seq;
  logic [pisc_pkg::WordBits-1:0] scr;
  logic [pisc_pkg::CrcBits-1:0]  crc;

  logic                          gold_out;
  logic                          n1;
  logic                          n2;
  logic [4:0]                    m;
  logic [1:0]                    v;
  logic [pisc_pkg::CntBits-1:0]  adv;
  logic [pisc_pkg::CntBits-1:0]  cnt_init;
  logic                          fb;

  assign gold_out = x1[0] ^ x2[0];
  assign n1       = x1[0] ^ x1[3];
  assign n2       = x2[0] ^ x2[1] ^ x2[2] ^ x2[3];

  // advance M*v: M = 26 for 64 blocks else 29, v = sfn[2:1]
  assign m        = lmax_is_64 ? 5'd26 : 5'd29;
  assign v        = in_data.frame_number[2:1];
  assign adv      = (v[1] ? {5'd0, m, 1'b0} : '0) + (v[0] ? {6'd0, m} : '0);
  assign cnt_init = pisc_pkg::CntBits'(pisc_pkg::GoldSkip) + adv;

  assign fb = crc[pisc_pkg::CrcBits-1] ^ scr[idx];

  assign stat.cnt_last = (cnt == pisc_pkg::CntBits'(1));
  assign stat.idx_last = (idx == '1);
  assign stat.out_free = !out_valid || !out_stall;

  // item, Gold LFSR, skip counter, sequence, CRC and output registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word_a <= pisc_pkg::build_word(in_data, lmax_is_64);
      l64    <= lmax_is_64;
      x1     <= pisc_pkg::GoldBits'(1);
      x2     <= {21'd0, cell_id};
      cnt    <= cnt_init;
    end
    if (cmd.gold_step) begin
      x1  <= {n1, x1[pisc_pkg::GoldBits-1:1]};
      x2  <= {n2, x2[pisc_pkg::GoldBits-1:1]};
      cnt <= cnt - pisc_pkg::CntBits'(1);
    end
    if (cmd.seq_step) begin
      x1  <= {n1, x1[pisc_pkg::GoldBits-1:1]};
      x2  <= {n2, x2[pisc_pkg::GoldBits-1:1]};
      seq <= {gold_out, seq[pisc_pkg::WordBits-1:1]};
    end
    if (cmd.scr_load) begin
      scr <= pisc_pkg::scramble(word_a, seq, l64);
      crc <= '0;
    end
    if (cmd.crc_step) begin
      crc <= {crc[pisc_pkg::CrcBits-2:0], 1'b0} ^ (fb ? pisc_pkg::CrcPoly : '0);
    end
    if (cmd.out_load) begin
      out_data.scrambled_word <= scr;
      out_data.crc_value      <= crc;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load || cmd.scr_load) begin
        idx <= '0;
      end else if (cmd.seq_step || cmd.crc_step) begin
        idx <= idx + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/pisc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pisc_ctrl
// Controller: sequences skip, sequence capture, scramble, CRC and hand-off.
// ----------------------------------------------------------------------------
module pisc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  pisc_pkg::dp_stat_t stat,
  output pisc_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    IDLE,
    SKIP,
    SEQ,
    SCR,
    CRC,
    HOLD
  } state_t;

  state_t state;

  assign in_stall = (state != IDLE);

  always_comb begin
    cmd           = '0;
    cmd.load      = (state == IDLE) && in_valid;
    cmd.gold_step = (state == SKIP);
    cmd.seq_step  = (state == SEQ);
    cmd.scr_load  = (state == SCR);
    cmd.crc_step  = (state == CRC);
    cmd.out_load  = (state == HOLD) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (in_valid) state <= SKIP;
        end
        SKIP: begin
          if (stat.cnt_last) state <= SEQ;
        end
        SEQ: begin
          if (stat.idx_last) state <= SCR;
        end
        SCR: begin
          state <= CRC;
        end
        CRC: begin
          if (stat.idx_last) state <= HOLD;
        end
        HOLD: begin
          if (stat.out_free) state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/pbch_payload_interleave_scramble_crc_top.sv =====
// ----------------------------------------------------------------------------
// pbch_payload_interleave_scramble_crc_top
// Items are taken one at a time: a new item is accepted only while idle,
//   after the previous result has moved to the output register. The Gold
//   LFSR steps one position per cycle over 1600 + M*v + 32 positions, with
//   M = 29 (26 with 64 blocks) and v = sfn[2:1].
// Reset (rst, synchronous): controller idle, output empty, cell_id and
//   lmax_is_64 cleared to 0.
// ----------------------------------------------------------------------------
module pbch_payload_interleave_scramble_crc_top (
  input  logic                clk,
  input  logic                rst,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  pisc_pkg::in_item_t  in_data,
  // output channel
  output logic                out_valid,
  input  logic                out_stall,
  output pisc_pkg::out_item_t out_data,
  // configuration write port
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [9:0]          cfg_data
);

  // Configuration registers, sampled when a beat is taken. The user must write
  // them only while idle; the block does not enforce it. lmax_is_64 is held per item.
  logic [9:0] cell_id;
  logic       lmax_is_64;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_id    <= '0;
      lmax_is_64 <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pisc_pkg::CfgCellId: cell_id    <= cfg_data;
        pisc_pkg::CfgLmax64: lmax_is_64 <= cfg_data[0];
        default: ;
      endcase
    end
  end

  pisc_pkg::dp_cmd_t  cmd;
  pisc_pkg::dp_stat_t stat;

  // Controller: IDLE -> SKIP (1600 + M*v LFSR steps) -> SEQ (32 steps,
  // capture sequence) -> SCR (scramble word) -> CRC (32 bit
  // steps, position 0 first) -> HOLD (wait for output register) -> IDLE.
  pisc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: interleaver mapping on load, Gold sequence pair, scramble
  // with excluded positions, serial CRC24C, output register. The output
  // register frees the controller as soon as a result is parked there.
  pisc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_data    (in_data),
    .cell_id    (cell_id),
    .lmax_is_64 (lmax_is_64),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: PBCH payload interleave / scramble / CRC24C block
// Every accepted input beat is run through a local predictor (interleaver,
// Gold sequence with skip and advance, CRC24C) and every output beat is
// compared with the oldest prediction. A directed table comes first, then
// random phases under changing cell id and block-count settings, with random
// idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int NumDir      = 21;
  localparam int NumPhases   = 8;
  localparam int PhaseItems  = 34;
  localparam int HoldCycles  = 6000;   // long output hold-off, fills the block
  localparam int TailCycles  = 2000;   // a bit more than the worst item latency
  localparam int IdleLimit   = 40000;  // cycles with no beat on either side
  localparam int MaxReports  = 10;

  // slot -> word position of the 32-entry interleaver
  localparam logic [4:0] SlotPos [32] = '{
    5'd16, 5'd23, 5'd18, 5'd17, 5'd8,  5'd30, 5'd10, 5'd6,
    5'd24, 5'd7,  5'd0,  5'd5,  5'd3,  5'd2,  5'd1,  5'd4,
    5'd9,  5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd19, 5'd20,
    5'd21, 5'd22, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd31
  };

  // directed row: settings to apply, then one input beat
  typedef struct packed {
    logic [9:0]         cid;
    logic               l64;
    pisc_pkg::in_item_t beat;
  } dir_row_t;

  // {cell id, l64, payload, frame_number, half_frame, block_index, k_ssb}
  localparam dir_row_t DirRows [NumDir] = '{
    {10'd0,    1'b0, 24'h000000, 10'h000, 1'b0, 6'h00, 5'h00}, // reset settings, zeros
    {10'd0,    1'b0, 24'hFFFFFF, 10'h3FF, 1'b1, 6'h3F, 5'h1F}, // all ones
    {10'd0,    1'b0, 24'h000001, 10'h000, 1'b0, 6'h00, 5'h00}, // element 0 only
    {10'd0,    1'b0, 24'h00007E, 10'h000, 1'b0, 6'h00, 5'h00}, // elements 1..6
    {10'd0,    1'b0, 24'h800000, 10'h000, 1'b0, 6'h00, 5'h00}, // last element
    {10'd0,    1'b0, 24'h000000, 10'h002, 1'b0, 6'h00, 5'h00}, // advance v = 1
    {10'd0,    1'b0, 24'h000000, 10'h004, 1'b0, 6'h00, 5'h00}, // advance v = 2
    {10'd0,    1'b0, 24'h000000, 10'h006, 1'b1, 6'h00, 5'h00}, // advance v = 3
    {10'd0,    1'b0, 24'h000000, 10'h009, 1'b0, 6'h00, 5'h00}, // sfn bits 3 and 0
    {10'd0,    1'b0, 24'h000000, 10'h3F0, 1'b0, 6'h07, 5'h0F}, // unused bits only
    {10'd0,    1'b0, 24'h000000, 10'h000, 1'b0, 6'h3F, 5'h10}, // k_ssb msb, index ignored
    {10'd1007, 1'b0, 24'hAAAAAA, 10'h006, 1'b1, 6'h00, 5'h1F}, // top cell id, max advance
    {10'd1007, 1'b0, 24'h555555, 10'h001, 1'b0, 6'h15, 5'h0A},
    {10'd1023, 1'b1, 24'h000000, 10'h000, 1'b0, 6'h38, 5'h00}, // cell id out of range
    {10'd1023, 1'b1, 24'hFFFFFF, 10'h3FF, 1'b1, 6'h07, 5'h1F}, // index low bits, k_ssb ignored
    {10'd1023, 1'b1, 24'h123456, 10'h006, 1'b1, 6'h3F, 5'h00}, // 64 blocks, max advance
    {10'd0,    1'b1, 24'h000000, 10'h000, 1'b0, 6'h00, 5'h00},
    {10'd0,    1'b1, 24'hFFFFFF, 10'h3FF, 1'b1, 6'h3F, 5'h1F},
    {10'd0,    1'b1, 24'h000000, 10'h004, 1'b0, 6'h20, 5'h00},
    {10'd1,    1'b0, 24'hC3A5F0, 10'h00A, 1'b1, 6'h08, 5'h10},
    {10'd512,  1'b1, 24'h0F0F0F, 10'h00D, 1'b0, 6'h18, 5'h1F}
  };

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  pisc_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  pisc_pkg::out_item_t out_data;
  logic                cfg_we;
  logic                cfg_index;
  logic [9:0]          cfg_data;

  // settings as the block holds them, for the predictor
  logic [9:0] cur_cell = '0;
  logic       cur_l64  = 1'b0;

  pisc_pkg::out_item_t pbch_word_q [$];
  int         fails      = 0;
  int         mismatches = 0;
  bit         quiet      = 1'b0;  // no idling on either side
  bit         hold_req   = 1'b0;  // ask the receiver for the long hold-off

  pbch_payload_interleave_scramble_crc_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: interleave, Gold scramble, CRC24C
  // --------------------------------------------------------------------------
  function automatic pisc_pkg::out_item_t predict_pbch_word(pisc_pkg::in_item_t it,
                                                            logic [9:0] cid,
                                                            logic l64);
    logic [31:0] slots;
    logic [31:0] word;
    logic [31:0] seq;
    logic [31:0] scr;
    logic [30:0] x1;
    logic [30:0] x2;
    logic [23:0] crc;
    logic        fb;
    logic        excluded;
    int          nadv;
    int          k;
    pisc_pkg::out_item_t r;
    slots = '0;
    word  = '0;
    seq   = '0;
    // payload element 0 and 7..23 fill slots 14..31, elements 1..6 slots 0..5
    for (int j = 0; j < 6; j++) slots[j] = it.payload_bits[j+1];
    slots[14] = it.payload_bits[0];
    for (int j = 15; j < 32; j++) slots[j] = it.payload_bits[j-8];
    slots[6]  = it.frame_number[3];
    slots[7]  = it.frame_number[2];
    slots[8]  = it.frame_number[1];
    slots[9]  = it.frame_number[0];
    slots[10] = it.half_frame;
    if (l64) begin
      slots[11] = it.block_index[5];
      slots[12] = it.block_index[4];
      slots[13] = it.block_index[3];
    end else begin
      slots[11] = it.subcarrier_offset[4];
      slots[12] = 1'b0;
      slots[13] = 1'b0;
    end
    for (int j = 0; j < 32; j++) word[SlotPos[j]] = slots[j];

    // Gold sequence: skip 1600, then advance M*v
    nadv = 1600 + (l64 ? 26 : 29) * int'({it.frame_number[2], it.frame_number[1]});
    x1 = 31'd1;
    x2 = {21'd0, cid};
    for (int n = 0; n < nadv + 32; n++) begin
      if (n >= nadv) seq[n-nadv] = x1[0] ^ x2[0];
      x1 = {x1[0] ^ x1[3], x1[30:1]};
      x2 = {x2[0] ^ x2[1] ^ x2[2] ^ x2[3], x2[30:1]};
    end

    // excluded positions pass through and do not consume sequence bits
    k = 0;
    for (int i = 0; i < 32; i++) begin
      excluded = (i == SlotPos[7]) || (i == SlotPos[8]) || (i == SlotPos[10]) ||
                 (l64 && ((i == SlotPos[11]) || (i == SlotPos[12]) ||
                          (i == SlotPos[13])));
      if (excluded) begin
        scr[i] = word[i];
      end else begin
        scr[i] = word[i] ^ seq[k];
        k++;
      end
    end

    crc = '0;
    for (int i = 0; i < 32; i++) begin
      fb  = crc[23] ^ scr[i];
      crc = {crc[22:0], 1'b0};
      if (fb) crc = crc ^ 24'hB2B117;
    end
    r.scrambled_word = scr;
    r.crc_value      = crc;
    return r;
  endfunction

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 95) return $urandom_range(1, 6);
    return $urandom_range(100, 2500);
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    fails++;
    mismatches++;
    if (mismatches <= MaxReports)
      $display("mismatch %s: expected %h, got %h", what, exp_v, act_v);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: predict on input beats, check on output beats (rising edge)
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : mon
    pisc_pkg::out_item_t want;
    if (!rst) begin
      if (in_valid && !in_stall)
        pbch_word_q.push_back(predict_pbch_word(in_data, cur_cell, cur_l64));
      if (out_valid && !out_stall) begin
        if (pbch_word_q.size() == 0) begin
          note_mismatch("unexpected beat", '0, out_data.scrambled_word);
        end else begin
          want = pbch_word_q.pop_front();
          if (out_data.scrambled_word !== want.scrambled_word)
            note_mismatch("scrambled_word", want.scrambled_word, out_data.scrambled_word);
          if (out_data.crc_value !== want.crc_value)
            note_mismatch("crc_value", 32'(want.crc_value), 32'(out_data.crc_value));
        end
      end
    end
  end

  // watchdog: too long with no beat on either channel
  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IdleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus the long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HoldCycles;
      end
      if (stall_left == 0 && !quiet && $urandom_range(0, 3) == 0)
        stall_left = pick_idle();
      out_stall = (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // offer one beat after a random gap and hold it until accepted
  task automatic send_beat(input pisc_pkg::in_item_t it);
    int gap;
    gap = pick_idle();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
  endtask

  // drop valid and wait for every predicted beat to come out
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pbch_word_q.size() != 0) @(posedge clk);
  endtask

  // settings change, only with the block empty
  task automatic write_settings(input logic [9:0] cid, input logic l64);
    logic [8:0] junk;
    junk = 9'($urandom);
    drain();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = pisc_pkg::CfgCellId;
    cfg_data  = cid;
    @(negedge clk);
    cfg_index = pisc_pkg::CfgLmax64;
    cfg_data  = {junk, l64};  // only bit 0 counts
    @(negedge clk);
    cfg_we   = 1'b0;
    cur_cell = cid;
    cur_l64  = l64;
  endtask

  initial begin : main
    pisc_pkg::in_item_t it;
    logic [9:0] cid;
    logic       l64;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = pisc_pkg::CfgCellId;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table; first rows run on the reset settings
    for (int r = 0; r < NumDir; r++) begin
      if (DirRows[r].cid !== cur_cell || DirRows[r].l64 !== cur_l64)
        write_settings(DirRows[r].cid, DirRows[r].l64);
      send_beat(DirRows[r].beat);
    end

    // random phases, each under its own settings
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin
          cid = 10'd1007;
          l64 = 1'b0;
        end
        1: begin
          cid = 10'd0;
          l64 = 1'b1;
        end
        2: begin
          cid = 10'd1023;
          l64 = 1'b0;
        end
        3: begin
          cid = 10'd1007;
          l64 = 1'b1;
        end
        default: begin
          cid = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(1008, 1023))
                                            : 10'($urandom_range(0, 1007));
          l64 = 1'($urandom);
        end
      endcase
      write_settings(cid, l64);
      quiet = (ph == 4);
      if (ph == 5) hold_req = 1'b1;
      for (int n = 0; n < PhaseItems; n++) begin
        it.payload_bits      = 24'($urandom);
        it.frame_number      = 10'($urandom);
        it.half_frame        = 1'($urandom);
        it.block_index       = 6'($urandom);
        it.subcarrier_offset = 5'($urandom);
        send_beat(it);
      end
    end
    quiet = 1'b0;

    drain();
    repeat (TailCycles) @(posedge clk);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
